// File: sv/nlb_pkg.sv
// Package for the normalized Legendre basis generator: widths, command/status
// structs, controller states and the normalization scale table.
// No dependencies.
`default_nettype none

package nlb_pkg;

   localparam int MAX_TERMS = 32;

   localparam int ABS_W  = 16;
   localparam int VAL_W  = 18;
   localparam int IDX_W  = 5;
   localparam int NT_W   = 6;
   localparam int FRAC_W = 14;

   localparam int CNT_W  = $clog2(MAX_TERMS);
   localparam int N_W    = CNT_W + 1;
   localparam int XP_W   = ABS_W + VAL_W;
   localparam int PQ_W   = VAL_W + CNT_W + 1;
   localparam int NUM_W  = XP_W + CNT_W + 2;
   localparam int DVD_W  = NUM_W - FRAC_W;
   localparam int Q_W    = VAL_W;

   localparam int DIV_RADIX  = 3;
   localparam int DIV_CYCLES = Q_W / DIV_RADIX;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam int SCALE_W = VAL_W;
   localparam int NP_W    = VAL_W + SCALE_W + 1;
   localparam int RND_W   = NP_W - FRAC_W;

   localparam int Q_MAX = 131071;
   localparam int Q_MIN_MAG = 131072;

   localparam logic [NT_W-1:0] NUM_TERMS_RESET = NT_W'(8);
   localparam logic signed [VAL_W-1:0] P_ONE = VAL_W'(1 << FRAC_W);
   localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'(Q_MAX);
   localparam logic signed [VAL_W-1:0] VAL_MIN = VAL_W'(Q_MIN_MAG);

   typedef struct packed {
      logic start;
      logic mul;
      logic num;
      logic mag;
      logic div_load;
      logic div_step;
      logic seed;
      logic take_q;
      logic norm_mul;
      logic norm_rnd;
      logic emit;
   } nlb_cmd_type;

   typedef struct packed {
      logic idx_low;
      logic last;
      logic out_free;
      logic div_done;
   } nlb_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TERM,
      ST_NUM,
      ST_MAG,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SAT,
      ST_NORM_MUL,
      ST_NORM_RND,
      ST_EMIT
   } ctrl_state_type;

   typedef logic [SCALE_W-1:0] scale_rom_type [MAX_TERMS];

   // round(sqrt((2i+1) * 2^27)) by bitwise integer square root
   function automatic scale_rom_type build_scale_rom();
      scale_rom_type rom;
      longint unsigned n;
      longint unsigned rem;
      longint unsigned root;
      longint unsigned bitv;
      for (int i = 0; i < MAX_TERMS; i++) begin
         n = longint'(2 * i + 1) << (2 * FRAC_W - 1);
         rem = n;
         root = 0;
         bitv = longint'(1) << 62;
         for (int k = 0; k < 32; k++) begin
            if (bitv > rem) begin
               bitv = bitv >> 2;
            end
         end
         for (int k = 0; k < 32; k++) begin
            if (bitv != 0) begin
               if (rem >= root + bitv) begin
                  rem = rem - (root + bitv);
                  root = (root >> 1) + bitv;
               end else begin
                  root = root >> 1;
               end
               bitv = bitv >> 2;
            end
         end
         if (n - root * root > root) begin
            root = root + 1;
         end
         rom[i] = SCALE_W'(root);
      end
      return rom;
   endfunction

   localparam scale_rom_type SCALE_ROM = build_scale_rom();

endpackage

`default_nettype wire

// File: sv/nlb_if.sv
// Channel interfaces of the normalized Legendre basis generator:
// abscissa requests, basis responses and the num_terms register write.
// Depends on nlb_pkg.
`default_nettype none

interface nlb_req_if;
   logic valid;
   logic ready;
   logic signed [nlb_pkg::ABS_W-1:0] abscissa;
   modport source (output valid, output abscissa, input ready);
   modport sink (input valid, input abscissa, output ready);
endinterface

interface nlb_rsp_if;
   logic valid;
   logic ready;
   logic [nlb_pkg::IDX_W-1:0] term_index;
   logic signed [nlb_pkg::VAL_W-1:0] basis_value;
   logic last_term;
   modport source (output valid, output term_index, output basis_value, output last_term,
                   input ready);
   modport sink (input valid, input term_index, input basis_value, input last_term,
                 output ready);
endinterface

interface nlb_csr_if;
   logic valid;
   logic ready;
   logic [nlb_pkg::NT_W-1:0] num_terms;
   modport source (output valid, output num_terms, input ready);
   modport sink (input valid, input num_terms, output ready);
endinterface

`default_nettype wire

// File: sv/normalized_legendre_basis.sv
// Top level of the normalized Legendre basis generator.
// Depends on nlb_pkg, nlb_if, nlb_ctrl, nlb_datapath.
//
//   channel  dir  payload                                 transaction
//   req_bus  in   abscissa (s16 Q1.14)                    valid & ready
//   rsp_bus  out  term_index, basis_value (s18), last     valid & ready
//   csr_bus  in   num_terms (u6)                          valid & ready
//
// Degrees 2 and up pass through the divider, which yields 3 quotient bits per cycle.
// A new abscissa is taken once the last term is in the output register.
// Synchronous active-high reset; num_terms resets to 8.
// A stalled rsp_bus holds the engine in its emit step.
`default_nettype none

module normalized_legendre_basis (
   input wire logic clock,
   input wire logic reset,
   nlb_req_if.sink   req_bus,
   nlb_rsp_if.source rsp_bus,
   nlb_csr_if.sink   csr_bus
);

   nlb_pkg::nlb_cmd_type    cmd;
   nlb_pkg::nlb_status_type status;

   nlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   nlb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .abscissa (req_bus.abscissa),
      .cmd      (cmd),
      .status   (status),
      .rsp_bus  (rsp_bus),
      .csr_bus  (csr_bus)
   );

endmodule

`default_nettype wire

// File: sv/nlb_div.sv
// Restoring divider for the recurrence: 18-bit quotient of a magnitude by the
// degree, DIV_RADIX quotient bits per cycle, with overflow flag.
// Depends on nlb_pkg.
`default_nettype none

module nlb_div (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic                          step,
   input  wire logic [nlb_pkg::DVD_W-1:0]     dividend,
   input  wire logic [nlb_pkg::CNT_W-1:0]     divisor,
   output      logic                          done,
   output      logic                          ovf,
   output      logic [nlb_pkg::Q_W-1:0]       quotient
);

   localparam int HI_W = nlb_pkg::DVD_W - nlb_pkg::Q_W;

   logic [nlb_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic [nlb_pkg::Q_W-1:0]       lo_ff, lo_in;
   logic [nlb_pkg::Q_W-1:0]       q_ff, q_in;
   logic                          ovf_ff, ovf_in;
   logic [nlb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [nlb_pkg::CNT_W:0]       trial;
   logic [HI_W-1:0]               hi;

   assign hi = dividend[nlb_pkg::DVD_W-1:nlb_pkg::Q_W];

   always_comb begin
      rem_in = rem_ff;
      lo_in  = lo_ff;
      q_in   = q_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      trial  = '0;
      if (load) begin
         rem_in = hi[nlb_pkg::CNT_W-1:0];
         lo_in  = dividend[nlb_pkg::Q_W-1:0];
         q_in   = '0;
         ovf_in = (hi >= HI_W'(divisor));
         cnt_in = '0;
      end else if (step) begin
         for (int k = 0; k < nlb_pkg::DIV_RADIX; k++) begin
            trial = {rem_in, lo_in[nlb_pkg::Q_W-1]};
            lo_in = {lo_in[nlb_pkg::Q_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
               rem_in = nlb_pkg::CNT_W'(trial - {1'b0, divisor});
               q_in   = {q_in[nlb_pkg::Q_W-2:0], 1'b1};
            end else begin
               rem_in = trial[nlb_pkg::CNT_W-1:0];
               q_in   = {q_in[nlb_pkg::Q_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + nlb_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
   end

   assign done     = (cnt_ff == nlb_pkg::DIV_CNT_W'(nlb_pkg::DIV_CYCLES - 1));
   assign ovf      = ovf_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: sv/nlb_datapath.sv
// Datapath: recurrence multipliers, rounding divider, normalization by the
// scale table, num_terms register and the response output register.
// Depends on nlb_pkg, nlb_if, nlb_div.
`default_nettype none

module nlb_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic signed [nlb_pkg::ABS_W-1:0] abscissa,
   input  wire nlb_pkg::nlb_cmd_type         cmd,
   output      nlb_pkg::nlb_status_type      status,
   nlb_rsp_if.source                         rsp_bus,
   nlb_csr_if.sink                           csr_bus
);

   logic [nlb_pkg::NT_W-1:0]              num_terms_ff, num_terms_in;
   logic [nlb_pkg::N_W-1:0]               n_eff;
   logic [nlb_pkg::CNT_W-1:0]             idx_ff, idx_in;
   logic signed [nlb_pkg::ABS_W-1:0]      x_ff;
   logic signed [nlb_pkg::VAL_W-1:0]      prev_ff, prev_prev_ff, p_ff;
   logic signed [nlb_pkg::XP_W-1:0]       xp_ff;
   logic signed [nlb_pkg::PQ_W-1:0]       pq_ff;
   logic signed [nlb_pkg::NUM_W-1:0]      num_ff;
   logic [nlb_pkg::NUM_W-1:0]             num_mag;
   logic [nlb_pkg::NUM_W-1:0]             num_rnd;
   logic [nlb_pkg::DVD_W-1:0]             dvd_ff;
   logic                                  neg_ff;
   logic [nlb_pkg::CNT_W:0]               coef;
   logic [nlb_pkg::CNT_W-1:0]             idx_m1;
   logic                                  div_done, div_ovf;
   logic [nlb_pkg::Q_W-1:0]               div_q;
   logic signed [nlb_pkg::VAL_W-1:0]      p_in;
   logic signed [nlb_pkg::NP_W-1:0]       np_ff;
   logic [nlb_pkg::NP_W-1:0]              np_mag;
   logic [nlb_pkg::RND_W-1:0]             np_rnd;
   logic signed [nlb_pkg::VAL_W-1:0]      basis_ff, basis_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [nlb_pkg::IDX_W-1:0]             rsp_idx_ff;
   logic signed [nlb_pkg::VAL_W-1:0]      rsp_val_ff;
   logic                                  rsp_last_ff;

   // num_terms register
   assign csr_bus.ready = 1'b1;
   assign num_terms_in = csr_bus.valid ? csr_bus.num_terms : num_terms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_terms_ff <= nlb_pkg::NUM_TERMS_RESET;
      end else begin
         num_terms_ff <= num_terms_in;
      end
   end

   always_comb begin
      if (num_terms_ff == '0) begin
         n_eff = nlb_pkg::N_W'(1);
      end else if ({1'b0, num_terms_ff} > (nlb_pkg::NT_W + 1)'(nlb_pkg::MAX_TERMS)) begin
         n_eff = nlb_pkg::N_W'(nlb_pkg::MAX_TERMS);
      end else begin
         n_eff = nlb_pkg::N_W'(num_terms_ff);
      end
   end

   // degree counter
   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         idx_in = '0;
      end else if (cmd.emit) begin
         idx_in = idx_ff + nlb_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign coef   = {idx_ff, 1'b0} - nlb_pkg::N_W'(1);
   assign idx_m1 = idx_ff - nlb_pkg::CNT_W'(1);

   // recurrence
   assign num_mag = num_ff[nlb_pkg::NUM_W-1] ? nlb_pkg::NUM_W'(-num_ff)
                                             : nlb_pkg::NUM_W'(num_ff);
   assign num_rnd = num_mag + (nlb_pkg::NUM_W'(idx_ff) << (nlb_pkg::FRAC_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff         <= abscissa;
         prev_ff      <= '0;
         prev_prev_ff <= '0;
      end else if (cmd.emit) begin
         prev_prev_ff <= prev_ff;
         prev_ff      <= p_ff;
      end
      if (cmd.mul) begin
         xp_ff <= nlb_pkg::XP_W'(x_ff) * nlb_pkg::XP_W'(prev_ff);
         pq_ff <= nlb_pkg::PQ_W'(prev_prev_ff) * nlb_pkg::PQ_W'($signed({1'b0, idx_m1}));
      end
      if (cmd.num) begin
         num_ff <= nlb_pkg::NUM_W'(xp_ff) * nlb_pkg::NUM_W'($signed({1'b0, coef}))
                 - (nlb_pkg::NUM_W'(pq_ff) <<< nlb_pkg::FRAC_W);
      end
      if (cmd.mag) begin
         dvd_ff <= num_rnd[nlb_pkg::NUM_W-1:nlb_pkg::FRAC_W];
         neg_ff <= num_ff[nlb_pkg::NUM_W-1];
      end
      if (cmd.seed || cmd.take_q) begin
         p_ff <= p_in;
      end
      if (cmd.norm_mul) begin
         np_ff <= nlb_pkg::NP_W'(p_ff)
                * nlb_pkg::NP_W'($signed({1'b0, nlb_pkg::SCALE_ROM[idx_ff]}));
      end
      if (cmd.norm_rnd) begin
         basis_ff <= basis_in;
      end
   end

   nlb_div u_div (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_ff),
      .divisor  (idx_ff),
      .done     (div_done),
      .ovf      (div_ovf),
      .quotient (div_q)
   );

   always_comb begin
      if (cmd.seed) begin
         p_in = (idx_ff == '0) ? nlb_pkg::P_ONE : nlb_pkg::VAL_W'(x_ff);
      end else if (neg_ff) begin
         if (div_ovf || (div_q > nlb_pkg::Q_W'(nlb_pkg::Q_MIN_MAG))) begin
            p_in = nlb_pkg::VAL_MIN;
         end else begin
            p_in = -$signed(div_q);
         end
      end else begin
         if (div_ovf || (div_q > nlb_pkg::Q_W'(nlb_pkg::Q_MAX))) begin
            p_in = nlb_pkg::VAL_MAX;
         end else begin
            p_in = $signed(div_q);
         end
      end
   end

   // normalization rounding
   assign np_mag = np_ff[nlb_pkg::NP_W-1] ? nlb_pkg::NP_W'(-np_ff) : nlb_pkg::NP_W'(np_ff);
   assign np_rnd = nlb_pkg::RND_W'((np_mag + (nlb_pkg::NP_W'(1) << (nlb_pkg::FRAC_W - 1)))
                                   >> nlb_pkg::FRAC_W);

   always_comb begin
      if (np_ff[nlb_pkg::NP_W-1]) begin
         if (np_rnd > nlb_pkg::RND_W'(nlb_pkg::Q_MIN_MAG)) begin
            basis_in = nlb_pkg::VAL_MIN;
         end else begin
            basis_in = -$signed(nlb_pkg::VAL_W'(np_rnd));
         end
      end else begin
         if (np_rnd > nlb_pkg::RND_W'(nlb_pkg::Q_MAX)) begin
            basis_in = nlb_pkg::VAL_MAX;
         end else begin
            basis_in = $signed(nlb_pkg::VAL_W'(np_rnd));
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_idx_ff  <= nlb_pkg::IDX_W'(idx_ff);
         rsp_val_ff  <= basis_ff;
         rsp_last_ff <= status.last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.term_index  = rsp_idx_ff;
   assign rsp_bus.basis_value = rsp_val_ff;
   assign rsp_bus.last_term   = rsp_last_ff;

   assign status.idx_low  = ({1'b0, idx_ff} < nlb_pkg::N_W'(2));
   assign status.last     = (({1'b0, idx_ff} + nlb_pkg::N_W'(1)) == n_eff);
   assign status.out_free = !rsp_valid_ff || rsp_bus.ready;
   assign status.div_done = div_done;

endmodule

`default_nettype wire

// File: sv/nlb_ctrl.sv
// Controller state machine: sequences each degree through recurrence and
// division (degrees 2 and up only), normalization and emission.
// Depends on nlb_pkg.
`default_nettype none

module nlb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire nlb_pkg::nlb_status_type status,
   output      nlb_pkg::nlb_cmd_type    cmd
);

   nlb_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nlb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         nlb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = nlb_pkg::ST_TERM;
            end
         end
         nlb_pkg::ST_TERM: begin
            if (status.idx_low) begin
               cmd.seed = 1'b1;
               state_in = nlb_pkg::ST_NORM_MUL;
            end else begin
               cmd.mul  = 1'b1;
               state_in = nlb_pkg::ST_NUM;
            end
         end
         nlb_pkg::ST_NUM: begin
            cmd.num  = 1'b1;
            state_in = nlb_pkg::ST_MAG;
         end
         nlb_pkg::ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = nlb_pkg::ST_DIV_LOAD;
         end
         nlb_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = nlb_pkg::ST_DIV;
         end
         nlb_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = nlb_pkg::ST_SAT;
            end
         end
         nlb_pkg::ST_SAT: begin
            cmd.take_q = 1'b1;
            state_in   = nlb_pkg::ST_NORM_MUL;
         end
         nlb_pkg::ST_NORM_MUL: begin
            cmd.norm_mul = 1'b1;
            state_in     = nlb_pkg::ST_NORM_RND;
         end
         nlb_pkg::ST_NORM_RND: begin
            cmd.norm_rnd = 1'b1;
            state_in     = nlb_pkg::ST_EMIT;
         end
         nlb_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last ? nlb_pkg::ST_IDLE : nlb_pkg::ST_TERM;
            end
         end
         default: begin
            state_in = nlb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/nlb_checker.sv
// Port-level checks for the normalized Legendre basis generator, bound to
// the top level. Depends on nlb_pkg and normalized_legendre_basis.
`default_nettype none

module nlb_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [nlb_pkg::IDX_W-1:0]   term_index,
   input wire logic [nlb_pkg::VAL_W-1:0]   basis_value,
   input wire logic                        last_term
);

   localparam logic [nlb_pkg::VAL_W-1:0] P0_VALUE = nlb_pkg::VAL_W'(11585);

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(term_index)
                                  && $stable(basis_value) && $stable(last_term))
      else $error("response changed while stalled");

   // busy right after taking an abscissa
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // more terms pending: no new abscissa
   a_no_req_midway: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_term |-> !req_ready)
      else $error("ready before last term");

   // degree zero is sqrt(1/2) in Q.14
   a_p0_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (term_index == '0) && (nlb_pkg::MAX_TERMS <= 32)
      |-> basis_value == P0_VALUE)
      else $error("wrong degree-zero value");

endmodule

bind normalized_legendre_basis nlb_checker u_nlb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .term_index  (rsp_bus.term_index),
   .basis_value (rsp_bus.basis_value),
   .last_term   (rsp_bus.last_term)
);

`default_nettype wire

// File: sim/testbench.sv
// Testbench for normalized_legendre_basis: directed table then random abscissas and
// num_terms settings, each response checked against typed values or a Legendre recurrence predictor.
// Depends on nlb_pkg, nlb_if and the RTL under sv/.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_ITEMS = 262;
   localparam int PHASE_ITEMS  = 66;
   localparam int TERMS_HOLD   = 16;
   localparam int MAX_REPORTS  = 50;
   localparam int N_ROWS       = 20;
   localparam logic signed [nlb_pkg::VAL_W-1:0] P0_BASIS = 18'sd11585;

   typedef struct packed {
      logic [nlb_pkg::IDX_W-1:0] term_index;
      logic signed [nlb_pkg::VAL_W-1:0] basis_value;
      logic last_term;
   } basis_term_type;

   // typed_count 0: predicted; 1: P0 only; 2: P0 and typed_p1
   typedef struct packed {
      logic write_terms;
      logic [nlb_pkg::NT_W-1:0] terms;
      logic signed [nlb_pkg::ABS_W-1:0] x;
      logic [1:0] typed_count;
      logic signed [nlb_pkg::VAL_W-1:0] typed_p1;
   } directed_row_type;

   directed_row_type directed_rows [N_ROWS] = '{
      '{1'b0, 6'd8,  16'sd0,      2'd0, 18'sd0},
      '{1'b0, 6'd8,  16'sd9000,   2'd0, 18'sd0},
      '{1'b1, 6'd1,  16'sd12345,  2'd1, 18'sd0},
      '{1'b1, 6'd0,  -16'sd5000,  2'd1, 18'sd0},
      '{1'b1, 6'd2,  16'sd0,      2'd2, 18'sd0},
      '{1'b0, 6'd2,  16'sd16384,  2'd2, 18'sd20066},
      '{1'b0, 6'd2,  -16'sd16384, 2'd2, -18'sd20066},
      '{1'b0, 6'd2,  16'sh8000,   2'd2, -18'sd40132},
      '{1'b1, 6'd32, 16'sd16384,  2'd0, 18'sd0},
      '{1'b0, 6'd32, -16'sd16384, 2'd0, 18'sd0},
      '{1'b0, 6'd32, 16'sd32767,  2'd0, 18'sd0},
      '{1'b0, 6'd32, 16'sh8000,   2'd0, 18'sd0},
      '{1'b0, 6'd32, 16'sd0,      2'd0, 18'sd0},
      '{1'b1, 6'd63, 16'sd8192,   2'd0, 18'sd0},
      '{1'b1, 6'd33, -16'sd12000, 2'd0, 18'sd0},
      '{1'b1, 6'd3,  16'sd21845,  2'd0, 18'sd0},
      '{1'b1, 6'd31, -16'sd21846, 2'd0, 18'sd0},
      '{1'b1, 6'd5,  -16'sd1,     2'd0, 18'sd0},
      '{1'b0, 6'd5,  16'sd1,      2'd0, 18'sd0},
      '{1'b1, 6'd1,  16'sh8000,   2'd1, 18'sd0}
   };

   logic clock;
   logic reset;

   nlb_req_if req_bus ();
   nlb_rsp_if rsp_bus ();
   nlb_csr_if csr_bus ();

   logic [nlb_pkg::NT_W-1:0] terms_setting = nlb_pkg::NUM_TERMS_RESET;
   basis_term_type basis_queue [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int src_idle_pct = 0;
   int sink_stall_pct = 0;

   normalized_legendre_basis i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint clamp_q(longint v);
      if (v > nlb_pkg::Q_MAX) return nlb_pkg::Q_MAX;
      if (v < -nlb_pkg::Q_MIN_MAG) return -nlb_pkg::Q_MIN_MAG;
      return v;
   endfunction

   // sqrt((2i+1)/2) in Q.14, rounded to nearest
   function automatic longint normalization_scale(int degree);
      longint target;
      longint lo;
      longint hi;
      longint mid;
      target = longint'(2 * degree + 1) << (2 * nlb_pkg::FRAC_W - 1);
      lo = 0;
      hi = longint'(1) << 20;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= target) lo = mid;
         else hi = mid;
      end
      if (target - lo * lo > lo) lo++;
      return lo;
   endfunction

   function automatic void predict_basis_terms(logic signed [nlb_pkg::ABS_W-1:0] x);
      longint count;
      longint xv;
      longint p;
      longint p_prev;
      longint p_prev2;
      longint num;
      longint b;
      basis_term_type term;
      count = terms_setting;
      if (count < 1) count = 1;
      if (count > nlb_pkg::MAX_TERMS) count = nlb_pkg::MAX_TERMS;
      xv = x;
      p_prev = 0;
      p_prev2 = 0;
      for (int i = 0; i < count; i++) begin
         if (i == 0) begin
            p = longint'(1) << nlb_pkg::FRAC_W;
         end else if (i == 1) begin
            p = xv;
         end else begin
            num = longint'(2 * i - 1) * xv * p_prev
                - longint'(i - 1) * p_prev2 * (longint'(1) << nlb_pkg::FRAC_W);
            p = clamp_q(round_div(num, longint'(i) << nlb_pkg::FRAC_W));
         end
         p_prev2 = p_prev;
         p_prev = p;
         b = clamp_q(round_div(p * normalization_scale(i), longint'(1) << nlb_pkg::FRAC_W));
         term.term_index = nlb_pkg::IDX_W'(i);
         term.basis_value = nlb_pkg::VAL_W'(b);
         term.last_term = (i + 1 == count);
         basis_queue.push_back(term);
      end
   endfunction

   function automatic logic signed [nlb_pkg::ABS_W-1:0] random_abscissa();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return nlb_pkg::ABS_W'(int'($urandom_range(32768)) - 16384);
      if (sel < 90) return nlb_pkg::ABS_W'($urandom);
      case ($urandom_range(6))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sh8000;
         3: return 16'sd32767;
         4: return 16'sd1;
         5: return -16'sd1;
         default: return 16'sd0;
      endcase
   endfunction

   function automatic logic [nlb_pkg::NT_W-1:0] random_terms();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return nlb_pkg::NT_W'($urandom_range(8, 1));
      if (sel < 85) return nlb_pkg::NT_W'($urandom_range(32, 9));
      if (sel < 92) return '0;
      return nlb_pkg::NT_W'($urandom_range(63, 33));
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic send_abscissa(logic signed [nlb_pkg::ABS_W-1:0] x);
      req_bus.valid <= 1'b1;
      req_bus.abscissa <= x;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   // drain all outstanding terms before touching the register
   task automatic program_num_terms(logic [nlb_pkg::NT_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (basis_queue.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.num_terms <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      terms_setting = value;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      basis_term_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (basis_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected term %0d value %0d last %0b",
                                      rsp_bus.term_index, rsp_bus.basis_value,
                                      rsp_bus.last_term));
         end else begin
            want = basis_queue.pop_front();
            if (rsp_bus.term_index !== want.term_index)
               report_mismatch($sformatf("term_index %0d, want %0d",
                                         rsp_bus.term_index, want.term_index));
            if (rsp_bus.basis_value !== want.basis_value)
               report_mismatch($sformatf("term %0d basis_value %0d, want %0d",
                                         want.term_index, rsp_bus.basis_value,
                                         want.basis_value));
            if (rsp_bus.last_term !== want.last_term)
               report_mismatch($sformatf("term %0d last_term %0b, want %0b",
                                         want.term_index, rsp_bus.last_term,
                                         want.last_term));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d terms outstanding",
                  cycle_count, basis_queue.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      logic signed [nlb_pkg::ABS_W-1:0] x;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.abscissa <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.num_terms <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         row = directed_rows[r];
         if (row.write_terms) program_num_terms(row.terms);
         send_abscissa(row.x);
         if (row.typed_count == 0) begin
            predict_basis_terms(row.x);
         end else if (row.typed_count == 1) begin
            basis_queue.push_back('{nlb_pkg::IDX_W'(0), P0_BASIS, 1'b1});
         end else begin
            basis_queue.push_back('{nlb_pkg::IDX_W'(0), P0_BASIS, 1'b0});
            basis_queue.push_back('{nlb_pkg::IDX_W'(1), row.typed_p1, 1'b1});
         end
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % PHASE_ITEMS == 0) begin
            case (k / PHASE_ITEMS)
               0: begin
                  src_idle_pct = 0;
                  sink_stall_pct = 0;
               end
               1: begin
                  src_idle_pct = 52;
                  sink_stall_pct = 0;
               end
               2: begin
                  src_idle_pct = 0;
                  sink_stall_pct = 52;
               end
               default: begin
                  src_idle_pct = 32;
                  sink_stall_pct = 32;
               end
            endcase
         end
         if (k % TERMS_HOLD == 0) program_num_terms(random_terms());
         sender_gap();
         x = random_abscissa();
         send_abscissa(x);
         predict_basis_terms(x);
      end

      req_bus.valid <= 1'b0;
      while (basis_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
